### hdl/pfd_pkg.sv
// Shared constants and types of the preamble frame deframer.
package pfd_pkg;

   localparam int MAX_PAYLOAD = 512;
   localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] PRE_BYTE = 8'h55;
   localparam logic [7:0] SFD_BYTE = 8'hd5;
   localparam logic [2:0] PRE_LAST = 3'd6;

   typedef enum logic [3:0] {
      ST_PRE,
      ST_SFD,
      ST_TYPE_LO,
      ST_TYPE_HI,
      ST_LEN_LO,
      ST_LEN_HI,
      ST_PAYLOAD,
      ST_CHECK_A,
      ST_CHECK_B
   } parse_state_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_GOOD = 2'd1,
      KIND_BAD  = 2'd2
   } result_kind_type;

   typedef struct packed {
      logic        verdict;
      logic        good;
      logic [7:0]  data;
      logic [8:0]  index;
      logic [15:0] ftype;
      logic [9:0]  flen;
   } pfd_entry_type;

endpackage

### hdl/pfd_if.sv
// Request and response channel interfaces of the deframer.
interface pfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface pfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  data_byte;
   logic [8:0]  byte_index;
   logic [15:0] frame_type;
   logic [9:0]  frame_length;
   logic        last;
   modport source (output valid, output result_kind, output data_byte, output byte_index,
                   output frame_type, output frame_length, output last, input ready);
   modport sink (input valid, input result_kind, input data_byte, input byte_index,
                 input frame_type, input frame_length, input last, output ready);
endinterface

### hdl/preamble_frame_deframer_top.sv
// Top level of the preamble frame deframer.
// Takes one received byte per request and accepts a new byte every clock cycle while the
// response side keeps up. A byte is parsed in the cycle it is offered, and its response
// entry enters a two-entry queue at the accepting edge. The output register loads it from
// the queue once the register is free or its response is taken, and the response is valid
// while it sits there. Payload bytes come out as they arrive; a frame whose first check byte
// matched ends with one verdict response (good or bad) carrying type and length. Bytes
// that cause no response (preamble, header, first check byte) are taken at full rate too.
// When the response side stalls, the queue and output register absorb up to three
// responses before request ready drops.
module preamble_frame_deframer_top import pfd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pfd_req_if.sink   req_ch,
   pfd_rsp_if.source rsp_ch
);

   logic          q_push;
   logic          q_pop;
   logic          q_full;
   logic          q_empty;
   pfd_entry_type q_in_entry;
   pfd_entry_type q_head;

   pfd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_in_entry)
   );

   pfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .pop        (q_pop),
      .head_entry (q_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   pfd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

### hdl/pfd_front.sv
// Front part: preamble hunt, header capture, check sums and result entry generation.
module pfd_front import pfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   pfd_req_if.sink       req_ch,
   input  logic          q_full,
   output logic          q_push,
   output pfd_entry_type q_entry
);

   parse_state_type state_ff, state_in;
   logic [2:0]       pre_cnt_ff, pre_cnt_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       sum_a_ff, sum_a_in;
   logic [7:0]       sum_b_ff, sum_b_in;
   logic [15:0]      type_ff, type_in;
   logic [15:0]      len_ff, len_in;

   logic        accept;
   logic [7:0]  b;
   logic [15:0] full_len;
   logic [15:0] idx_next;
   logic [15:0] idx_wide;

   assign req_ch.ready = !q_full;
   assign accept = req_ch.valid && !q_full;
   assign b = req_ch.rx_byte;
   assign full_len = {b, len_ff[7:0]};
   assign idx_wide = 16'(idx_ff);
   assign idx_next = idx_wide + 16'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         case (state_ff)
            ST_PRE: begin
               if (b == PRE_BYTE && pre_cnt_ff == PRE_LAST) state_in = ST_SFD;
            end
            ST_SFD:     state_in = (b == SFD_BYTE) ? ST_TYPE_LO : ST_PRE;
            ST_TYPE_LO: state_in = ST_TYPE_HI;
            ST_TYPE_HI: state_in = ST_LEN_LO;
            ST_LEN_LO:  state_in = ST_LEN_HI;
            ST_LEN_HI: begin
               if (32'(full_len) > 32'(MAX_PAYLOAD)) state_in = ST_PRE;
               else if (full_len == 16'd0) state_in = ST_CHECK_A;
               else state_in = ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
               if (idx_next == len_ff) state_in = ST_CHECK_A;
            end
            ST_CHECK_A: state_in = (b == sum_a_ff) ? ST_CHECK_B : ST_PRE;
            ST_CHECK_B: state_in = ST_PRE;
            default:    state_in = ST_PRE;
         endcase
      end
   end

   // outputs
   always_comb begin
      q_push = 1'b0;
      q_entry.verdict = 1'b0;
      q_entry.good = 1'b0;
      q_entry.data = b;
      q_entry.index = idx_wide[8:0];
      q_entry.ftype = type_ff;
      q_entry.flen = len_ff[9:0];
      case (state_ff)
         ST_PAYLOAD: begin
            q_push = accept;
         end
         ST_CHECK_B: begin
            q_push = accept;
            q_entry.verdict = 1'b1;
            q_entry.good = (b == sum_b_ff);
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      pre_cnt_in = pre_cnt_ff;
      idx_in = idx_ff;
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      type_in = type_ff;
      len_in = len_ff;
      if (accept) begin
         case (state_ff)
            ST_PRE: begin
               if (b == PRE_BYTE && pre_cnt_ff != PRE_LAST) pre_cnt_in = pre_cnt_ff + 3'd1;
               else pre_cnt_in = 3'd0;
            end
            ST_TYPE_LO: begin
               sum_a_in = b;
               sum_b_in = b;
               type_in = {8'd0, b};
            end
            ST_TYPE_HI: begin
               sum_a_in = sum_a_ff + b;
               sum_b_in = sum_b_ff + sum_a_ff + b;
               type_in = {b, type_ff[7:0]};
            end
            ST_LEN_LO: begin
               sum_a_in = sum_a_ff + b;
               sum_b_in = sum_b_ff + sum_a_ff + b;
               len_in = {8'd0, b};
            end
            ST_LEN_HI: begin
               sum_a_in = sum_a_ff + b;
               sum_b_in = sum_b_ff + sum_a_ff + b;
               len_in = full_len;
               idx_in = '0;
            end
            ST_PAYLOAD: begin
               sum_a_in = sum_a_ff + b;
               sum_b_in = sum_b_ff + sum_a_ff + b;
               idx_in = idx_next[IDX_W-1:0];
            end
            default: begin
               pre_cnt_in = 3'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_PRE;
         pre_cnt_ff <= 3'd0;
         idx_ff <= '0;
         sum_a_ff <= 8'd0;
         sum_b_ff <= 8'd0;
         type_ff <= 16'd0;
         len_ff <= 16'd0;
      end else begin
         state_ff <= state_in;
         pre_cnt_ff <= pre_cnt_in;
         idx_ff <= idx_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         type_ff <= type_in;
         len_ff <= len_in;
      end
   end

endmodule

### hdl/pfd_queue.sv
// Short queue of result entries between the front and back parts.
module pfd_queue import pfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  pfd_entry_type push_entry,
   input  logic          pop,
   output pfd_entry_type head_entry,
   output logic          full,
   output logic          empty
);

   pfd_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      else if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### hdl/pfd_back.sv
// Back part: expands queued entries into response items and holds them in the output register.
module pfd_back import pfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  pfd_entry_type q_head,
   output logic          q_pop,
   pfd_rsp_if.source     rsp_ch
);

   logic            valid_ff, valid_in;
   result_kind_type kind_ff, kind_in;
   logic [7:0]      data_ff, data_in;
   logic [8:0]      index_ff, index_in;
   logic [15:0]     type_ff, type_in;
   logic [9:0]      len_ff, len_in;
   logic            last_ff, last_in;

   assign q_pop = !q_empty && (!valid_ff || rsp_ch.ready);

   always_comb begin
      valid_in = valid_ff;
      kind_in = kind_ff;
      data_in = data_ff;
      index_in = index_ff;
      type_in = type_ff;
      len_in = len_ff;
      last_in = last_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         if (q_head.verdict) begin
            kind_in = q_head.good ? KIND_GOOD : KIND_BAD;
            data_in = 8'd0;
            index_in = 9'd0;
         end else begin
            kind_in = KIND_DATA;
            data_in = q_head.data;
            index_in = q_head.index;
         end
         type_in = q_head.ftype;
         len_in = q_head.flen;
         last_in = q_head.verdict;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      data_ff <= data_in;
      index_ff <= index_in;
      type_ff <= type_in;
      len_ff <= len_in;
      last_ff <= last_in;
   end

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.result_kind = kind_ff;
   assign rsp_ch.data_byte = data_ff;
   assign rsp_ch.byte_index = index_ff;
   assign rsp_ch.frame_type = type_ff;
   assign rsp_ch.frame_length = len_ff;
   assign rsp_ch.last = last_ff;

endmodule
